[hdl/plist_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants for the positional list block.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned PosW        = 3;
  localparam int unsigned CntW        = 4;
  localparam int unsigned CapacityDef = 8;
  localparam int unsigned PosSpan     = 1 << PosW;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // broadcast to every cell in the row
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] value;
  } cell_ctrl_t;

endpackage

[hdl/plist_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_cell
// One list slot: loads from its left neighbor on insert, from its right
// neighbor on delete, or the new value when it sits at the insert position.
// ----------------------------------------------------------------------------
module plist_cell
  import plist_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CMP_W = 3
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  output logic [DataW-1:0] data_o
);

  localparam logic [CMP_W-1:0] MyIdx = CMP_W'(IDX);

  logic [DataW-1:0] data_q, data_d;
  logic [CMP_W-1:0] pos_x;

  assign pos_x = CMP_W'(ctrl_i.pos);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (MyIdx > pos_x) begin
        data_d = left_i;
      end else if (MyIdx == pos_x) begin
        data_d = ctrl_i.value;
      end
    end else if (ctrl_i.del && (MyIdx >= pos_x)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[hdl/positional_list_insert_delete_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top
// Bounded ordered list of signed 32-bit entries held in a row of cells.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                      tuser
//  s_axis   in   value[31:0], position[34:32], pad       cmd[1:0]
//  m_axis   out  read_value[31:0], count[35:32], pad     status[1:0]
//
// The whole shift happens in the cell row on the edge that accepts a request,
// and the result lands in the output register.
// One request per cycle is sustained while m_axis_tready is high; a stalled
// result holds the output register and blocks s_axis_tready.
// Reset clears the length and the output valid; entries are not reset.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top
  import plist_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value[31:0], position[34:32], zero pad
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_value[31:0], count[35:32], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  // length holds 0..CAPACITY
  localparam int unsigned LenW  = $clog2(CAPACITY + 1);
  // common width for position / length compares
  localparam int unsigned CmpW  = (LenW > PosW) ? LenW : PosW;
  localparam int unsigned LenXW = (LenW > CntW) ? LenW : CntW;
  localparam logic [LenW-1:0] Cap = LenW'(CAPACITY);

  // ---- input unpack
  logic             accept;
  cmd_e             cmd;
  logic [DataW-1:0] in_value;
  logic [PosW-1:0]  in_pos;

  assign cmd      = cmd_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[DataW-1:0];
  assign in_pos   = s_axis_tdata[DataW+PosW-1:DataW];

  // ---- state
  logic [LenW-1:0]  len_q, len_d;
  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [DataW-1:0] rdata_q, rdata_d;
  logic [CntW-1:0]  count_q;
  logic [LenXW-1:0] len_x;

  // accept while the output slot is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---- cell row
  cell_ctrl_t       ctrl;
  logic [DataW-1:0] cell_q [CAPACITY];
  logic [DataW-1:0] rd_tap [PosSpan];

  logic [CmpW-1:0] pos_x, len_c;
  assign pos_x = CmpW'(in_pos);
  assign len_c = CmpW'(len_q);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DataW-1:0] left, right;
      if (gi == 0) begin : g_first
        assign left = in_value;            // never shifted into slot zero
      end else begin : g_mid_l
        assign left = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right = '0;                 // vacated top slot, unreadable
      end else begin : g_mid_r
        assign right = cell_q[gi+1];
      end
      plist_cell #(
        .IDX   (gi),
        .CMP_W (CmpW)
      ) u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl),
        .left_i  (left),
        .right_i (right),
        .data_o  (cell_q[gi])
      );
    end

    // read taps: only the first positions are addressable
    for (gi = 0; gi < PosSpan; gi++) begin : g_tap
      if (gi < CAPACITY) begin : g_on
        assign rd_tap[gi] = cell_q[gi];
      end else begin : g_off
        assign rd_tap[gi] = '0;
      end
    end
  endgenerate

  // ---- command decode and status
  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.pos   = in_pos;
    ctrl.value = in_value;
    status_d   = ST_OK;
    rdata_d    = '0;
    len_d      = len_q;
    case (cmd)
      CMD_INSERT: begin
        if (len_q >= Cap) begin
          status_d = ST_FULL;
        end else if (pos_x > len_c) begin
          status_d = ST_BADPOS;
        end else begin
          ctrl.ins = accept;
          len_d    = len_q + LenW'(1);
        end
      end
      CMD_DELETE: begin
        if (len_q == '0) begin
          status_d = ST_EMPTY;
        end else if (pos_x >= len_c) begin
          status_d = ST_BADPOS;
        end else begin
          ctrl.del = accept;
          len_d    = len_q - LenW'(1);
        end
      end
      CMD_READ: begin
        if (len_q == '0) begin
          status_d = ST_EMPTY;
        end else if (pos_x >= len_c) begin
          status_d = ST_BADPOS;
        end else begin
          rdata_d = rd_tap[in_pos];
        end
      end
      CMD_CLEAR: begin
        len_d = '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign len_x = LenXW'(len_d);

  // ---- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        len_q       <= len_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rdata_q  <= rdata_d;
      count_q  <= len_x[CntW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {4'b0000, count_q, rdata_q};

endmodule

[dv/positional_list_insert_delete_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top_test
// Self-checking bench for the positional list. A local model of the list
// predicts status, read value and length for every accepted request; a
// directed pass covers the corner cases, then ~1400 random requests follow,
// with random valid/ready gaps on both streams outside one full-rate stretch.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top_test;
  import plist_pkg::*;

  localparam int unsigned ListCap = CapacityDef;
  localparam int unsigned NumRandom = 1400;

  typedef struct {
    logic [1:0]       status;
    logic [DataW-1:0] rd_value;
    logic [CntW-1:0]  count;
  } list_reply_t;

  // Predicts the reply of each accepted request and checks the replies
  // that come back, oldest first.
  class plist_scoreboard;
    logic [DataW-1:0] cells[ListCap];
    int               fill;
    list_reply_t      replies_q[$];
    int unsigned      mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return replies_q.size();
    endfunction

    function void note_request(cmd_e op, logic [DataW-1:0] val, logic [PosW-1:0] pos);
      list_reply_t r;
      r.status   = ST_OK;
      r.rd_value = '0;
      case (op)
        CMD_INSERT: begin
          if (fill >= ListCap) begin
            r.status = ST_FULL;
          end else if (int'(pos) > fill) begin
            r.status = ST_BADPOS;
          end else begin
            for (int k = fill; k > int'(pos); k--) cells[k] = cells[k-1];
            cells[pos] = val;
            fill++;
          end
        end
        CMD_DELETE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (int'(pos) >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            for (int k = int'(pos); k + 1 < fill; k++) cells[k] = cells[k+1];
            fill--;
          end
        end
        CMD_READ: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (int'(pos) >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            r.rd_value = cells[pos];
          end
        end
        default: begin
          fill = 0;
        end
      endcase
      r.count = fill[CntW-1:0];
      replies_q.push_back(r);
    endfunction

    function void check_reply(logic [1:0] st, logic [DataW-1:0] rd, logic [CntW-1:0] cnt);
      list_reply_t e;
      if (replies_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: reply with nothing outstanding: status %0d value %h count %0d",
                   $time, st, rd, cnt);
        return;
      end
      e = replies_q.pop_front();
      if (st !== e.status || rd !== e.rd_value || cnt !== e.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: exp status %0d value %h count %0d, got %0d %h %0d",
                   $time, e.status, e.rd_value, e.count, st, rd, cnt);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // value[31:0], position[34:32], zero pad
  logic [1:0]  s_axis_tuser;   // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // read_value[31:0], count[35:32], zero pad
  logic [1:0]  m_axis_tuser;   // status[1:0]

  plist_scoreboard book;
  bit              idle_en;    // random gaps on both streams when set

  positional_list_insert_delete_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Sends one request; valid stays high after acceptance so back-to-back
  // requests need no bubble. Signals read right after the edge are the
  // values that decided the handshake.
  task automatic send_request(cmd_e op, logic [DataW-1:0] val, logic [PosW-1:0] pos);
    if (idle_en) begin
      while ($urandom_range(0, 99) < 27) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, pos, val};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_request(op, val, pos);
  endtask

  // Holds off new requests until every reply is back.
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
  endtask

  // Mostly well-formed requests at legal positions, shaped by the current
  // fill, with a slice of arbitrary noise.
  task automatic send_random_request();
    int               r;
    int               fill;
    cmd_e             op;
    logic [DataW-1:0] val;
    logic [PosW-1:0]  pos;
    fill = book.fill;
    r    = $urandom_range(0, 99);
    val  = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        2: val = 32'h0000_0000;
        default: val = 32'hffff_ffff;
      endcase
    end
    pos = PosW'($urandom_range(0, 7));
    if (r < 38) begin
      op  = CMD_INSERT;
      pos = PosW'($urandom_range(0, (fill < 7) ? fill : 7));
    end else if (r < 63) begin
      op = CMD_DELETE;
      if (fill > 0) pos = PosW'($urandom_range(0, fill - 1));
    end else if (r < 88) begin
      op = CMD_READ;
      if (fill > 0) pos = PosW'($urandom_range(0, fill - 1));
    end else if (r < 93) begin
      op = CMD_CLEAR;
    end else begin
      op = cmd_e'(2'($urandom_range(0, 3)));
    end
    send_request(op, val, pos);
  endtask

  // Result side: random back-pressure when idle_en is set, check on every accepted reply.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        book.check_reply(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[35:32]);
      m_axis_tready <= !idle_en || ($urandom_range(0, 99) >= 27);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_CLEAR;
    idle_en       = 1'b1;
    book          = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, bad positions, fill to capacity, extremes
    send_request(CMD_CLEAR,  32'h0,         3'd0);
    send_request(CMD_READ,   32'h0,         3'd0);   // read empty
    send_request(CMD_DELETE, 32'h0,         3'd0);   // delete empty
    send_request(CMD_INSERT, 32'h1111_1111, 3'd1);   // past the end
    send_request(CMD_INSERT, 32'h8000_0000, 3'd0);
    send_request(CMD_INSERT, 32'h7fff_ffff, 3'd1);   // append
    send_request(CMD_INSERT, 32'h0000_0000, 3'd1);   // middle
    send_request(CMD_INSERT, 32'hffff_ffff, 3'd0);
    send_request(CMD_INSERT, 32'h0000_0001, 3'd4);
    send_request(CMD_INSERT, 32'h2222_2222, 3'd7);   // past the end
    send_request(CMD_INSERT, 32'ha5a5_a5a5, 3'd2);
    send_request(CMD_INSERT, 32'h5a5a_5a5a, 3'd6);
    send_request(CMD_INSERT, 32'h1234_5678, 3'd7);   // now full
    send_request(CMD_INSERT, 32'hdead_beef, 3'd0);   // full rejects a legal position
    send_request(CMD_READ,   32'h0,         3'd7);
    send_request(CMD_READ,   32'h0,         3'd0);
    send_request(CMD_DELETE, 32'hffff_ffff, 3'd7);
    send_request(CMD_READ,   32'h0,         3'd7);   // out of range
    send_request(CMD_DELETE, 32'h0,         3'd0);   // position zero is legal
    send_request(CMD_DELETE, 32'h0,         3'd6);   // out of range
    send_request(CMD_READ,   32'h0,         3'd3);
    send_request(CMD_CLEAR,  32'h0,         3'd5);
    send_request(CMD_READ,   32'h0,         3'd0);   // empty after clear
    send_request(CMD_INSERT, 32'h0,         3'd0);
    send_request(CMD_DELETE, 32'h0,         3'd0);

    drain_replies();

    for (int n = 0; n < NumRandom; n++) begin
      idle_en = !(n >= 500 && n < 800);   // one long stretch at full rate
      if (n == 900) drain_replies();
      send_random_request();
    end

    idle_en = 1'b1;
    drain_replies();
    repeat (8) @(posedge clk_i);

    if (book.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[positional_list_insert_delete_top.f]
hdl/plist_pkg.sv
hdl/plist_cell.sv
hdl/positional_list_insert_delete_top.sv
dv/positional_list_insert_delete_top_test.sv
